/* hw/rtl/snue_pkg.sv */
// Package for the spiking neuron update engine.
// Holds item, result and pipeline types, Q11.20 constants and saturating helpers.
// Depends on nothing.
`default_nettype none

package snue_pkg;

	localparam int IDX_W      = 10;
	localparam int ADDR_W     = 16;
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = 2;
	localparam int QCNT_W     = 3;
	localparam int SUB_STAGES = 9;

	typedef logic signed [31:0] q_t;
	typedef logic signed [63:0] prod_t;

	localparam q_t K_004    = 32'sd41943;
	localparam q_t K_FIVE   = 32'sd5242880;
	localparam q_t K_140    = 32'sd146800640;
	localparam q_t K_THRESH = 32'sd31457280;
	localparam q_t Q_MAX    = 32'sh7fffffff;
	localparam q_t Q_MIN    = 32'sh80000000;

	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_UPDATE = 1'b1;

	typedef struct packed {
		logic             action;
		logic [IDX_W-1:0] neuron_index;
		logic             stimulated;
		q_t               current;
		q_t               load_a;
		q_t               load_b;
		q_t               load_c;
		q_t               load_d;
		q_t               load_u;
		q_t               load_v;
	} cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0] out_index;
		logic             fired;
		q_t               potential;
		q_t               recovery;
	} res_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [ADDR_W-1:0] addr;
	} entry_t;

	typedef struct packed {
		logic   vld;
		entry_t head;
	} qhead_t;

	typedef struct packed {
		logic              load;
		logic [IDX_W-1:0]  idx;
		logic [ADDR_W-1:0] addr;
		logic              stim;
		q_t                cur;
		q_t                a;
		q_t                b;
		q_t                c;
		q_t                d;
		q_t                u;
		q_t                v;
		q_t                t;
		prod_t             p;
		logic              fired;
	} stage_t;

	function automatic q_t sat33(logic signed [32:0] x);
		if (x[32] != x[31]) begin
			return x[32] ? Q_MIN : Q_MAX;
		end
		return x[31:0];
	endfunction

	function automatic q_t qadd(q_t x, q_t y);
		logic signed [32:0] s;
		s = 33'(x) + 33'(y);
		return sat33(s);
	endfunction

	function automatic q_t qsub(q_t x, q_t y);
		logic signed [32:0] s;
		s = 33'(x) - 33'(y);
		return sat33(s);
	endfunction

	function automatic q_t qstep(q_t x, q_t t);
		logic signed [32:0] s;
		s = 33'(x) + 33'(t >>> 2);
		return sat33(s);
	endfunction

	function automatic q_t qscale(prod_t p);
		logic signed [43:0] s;
		s = 44'(p >>> 20);
		if (s[43:31] == '0 || s[43:31] == '1) begin
			return s[31:0];
		end
		return s[43] ? Q_MIN : Q_MAX;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/snue_front.sv */
// Front end: accepts items, maps the index onto the table, queues entries.
// Depends on snue_pkg.
`default_nettype none

module snue_front #(
	parameter int NEURONS = 1024
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire snue_pkg::cmd_t  cmd,
	output logic                 busy,
	output snue_pkg::qhead_t     qh,
	input  wire logic            pop
);

	logic                            acc;
	logic                            vld_s1;
	snue_pkg::cmd_t                  cmd_s1;
	logic [snue_pkg::ADDR_W-1:0]     addr_s1;
	snue_pkg::entry_t                fifo_q [snue_pkg::QDEPTH];
	logic [snue_pkg::QPTR_W-1:0]     wp_q;
	logic [snue_pkg::QPTR_W-1:0]     rp_q;
	logic [snue_pkg::QCNT_W-1:0]     cnt_q;

	assign busy = cnt_q >= snue_pkg::QCNT_W'(snue_pkg::QDEPTH - 1);
	assign acc  = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_s1 <= cmd;
		end
	end

	generate
		if (NEURONS >= 1024) begin : g_direct
			assign addr_s1 = snue_pkg::ADDR_W'(cmd_s1.neuron_index);
		end else begin : g_mod
			localparam int RECIP = (2**21 + NEURONS - 1) / NEURONS;
			logic [31:0]                quo_prod;
			logic [snue_pkg::IDX_W-1:0] quo_s1;
			logic [snue_pkg::IDX_W-1:0] rem;
			assign quo_prod = 32'(cmd.neuron_index) * 32'(RECIP);
			always_ff @(posedge clk) begin
				if (acc) begin
					quo_s1 <= quo_prod[30:21];
				end
			end
			assign rem = cmd_s1.neuron_index
				- snue_pkg::IDX_W'(quo_s1 * snue_pkg::IDX_W'(NEURONS));
			assign addr_s1 = snue_pkg::ADDR_W'(rem);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (vld_s1) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + snue_pkg::QCNT_W'(vld_s1) - snue_pkg::QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			fifo_q[wp_q] <= '{cmd: cmd_s1, addr: addr_s1};
		end
	end

	assign qh.vld  = cnt_q != '0;
	assign qh.head = fifo_q[rp_q];

endmodule

`default_nettype wire

/* hw/rtl/snue_substep.sv */
// One Euler substep as a nine-stage pipeline, with an address probe for hazards.
// Depends on snue_pkg.
`default_nettype none

module snue_substep (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_vld,
	input  wire snue_pkg::stage_t            in_stg,
	input  wire logic [snue_pkg::ADDR_W-1:0] probe,
	output logic                             out_vld,
	output snue_pkg::stage_t                 out_stg,
	output logic                             hit
);

	localparam int N = snue_pkg::SUB_STAGES;

	logic [N-1:0]     vld_q;
	snue_pkg::stage_t stg_q [N];
	snue_pkg::stage_t src [N];
	snue_pkg::stage_t nxt [N];

	assign src[0] = in_stg;
	for (genvar k = 1; k < N; k++) begin : g_src
		assign src[k] = stg_q[k-1];
	end

	always_comb begin
		nxt = src;
		nxt[0].p = src[0].v * snue_pkg::K_004;
		nxt[1].t = snue_pkg::qadd(snue_pkg::qscale(src[1].p), snue_pkg::K_FIVE);
		nxt[2].p = src[2].t * src[2].v;
		nxt[3].t = snue_pkg::qsub(snue_pkg::qadd(snue_pkg::qscale(src[3].p), snue_pkg::K_140),
			src[3].u);
		nxt[4].t = snue_pkg::qadd(src[4].t, src[4].cur);
		if (!(src[4].load || src[4].fired)) begin
			nxt[4].v = snue_pkg::qstep(src[4].v, nxt[4].t);
		end
		nxt[5].p = src[5].b * src[5].v;
		nxt[6].t = snue_pkg::qsub(snue_pkg::qscale(src[6].p), src[6].u);
		nxt[7].p = src[7].a * src[7].t;
		if (!(src[8].load || src[8].fired)) begin
			nxt[8].u     = snue_pkg::qstep(src[8].u, snue_pkg::qscale(src[8].p));
			nxt[8].fired = src[8].v >= snue_pkg::K_THRESH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[N-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		stg_q <= nxt;
	end

	always_comb begin
		hit = 1'b0;
		for (int k = 0; k < N; k++) begin
			hit = hit | (vld_q[k] && stg_q[k].addr == probe);
		end
	end

	assign out_vld = vld_q[N-1];
	assign out_stg = stg_q[N-1];

endmodule

`default_nettype wire

/* hw/rtl/snue_back.sv */
// Back end: neuron table memories, substep chain, spike reset and write-back.
// Depends on snue_pkg and snue_substep.
`default_nettype none

module snue_back #(
	parameter int NEURONS       = 1024,
	parameter int SUBSTEP_COUNT = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire snue_pkg::qhead_t qh,
	output logic                  pop,
	output logic                  done,
	output snue_pkg::res_t        result
);

	localparam int AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;

	logic [127:0]           param_mem [NEURONS];
	logic [63:0]            state_mem [NEURONS];
	logic [127:0]           rd_param_s0;
	logic [63:0]            rd_state_s0;
	logic                   vld_s0;
	snue_pkg::entry_t       ent_s0;
	logic                   chv [SUBSTEP_COUNT+1];
	snue_pkg::stage_t       chn [SUBSTEP_COUNT+1];
	logic [SUBSTEP_COUNT-1:0] hits;
	logic                   hazard;
	snue_pkg::stage_t       tl;
	logic                   fired_f;
	snue_pkg::q_t           v_f;
	snue_pkg::q_t           u_f;
	logic                   done_q;
	snue_pkg::res_t         res_q;

	assign hazard = (vld_s0 && ent_s0.addr == qh.head.addr) || (|hits);
	assign pop    = qh.vld && !hazard;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else begin
			vld_s0 <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_s0      <= qh.head;
			rd_param_s0 <= param_mem[qh.head.addr[AW-1:0]];
			rd_state_s0 <= state_mem[qh.head.addr[AW-1:0]];
		end
	end

	always_comb begin
		chn[0].load  = ent_s0.cmd.action == snue_pkg::ACT_LOAD;
		chn[0].idx   = ent_s0.cmd.neuron_index;
		chn[0].addr  = ent_s0.addr;
		chn[0].stim  = ent_s0.cmd.stimulated;
		chn[0].cur   = ent_s0.cmd.current;
		chn[0].t     = '0;
		chn[0].p     = '0;
		chn[0].fired = 1'b0;
		if (chn[0].load) begin
			chn[0].a = ent_s0.cmd.load_a;
			chn[0].b = ent_s0.cmd.load_b;
			chn[0].c = ent_s0.cmd.load_c;
			chn[0].d = ent_s0.cmd.load_d;
			chn[0].u = ent_s0.cmd.load_u;
			chn[0].v = ent_s0.cmd.load_v;
		end else begin
			chn[0].a = rd_param_s0[127:96];
			chn[0].b = rd_param_s0[95:64];
			chn[0].c = rd_param_s0[63:32];
			chn[0].d = rd_param_s0[31:0];
			chn[0].u = rd_state_s0[63:32];
			chn[0].v = rd_state_s0[31:0];
		end
	end
	assign chv[0] = vld_s0;

	for (genvar g = 0; g < SUBSTEP_COUNT; g++) begin : g_sub
		snue_substep u_sub (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_vld  (chv[g]),
			.in_stg  (chn[g]),
			.probe   (qh.head.addr),
			.out_vld (chv[g+1]),
			.out_stg (chn[g+1]),
			.hit     (hits[g])
		);
	end

	assign tl      = chn[SUBSTEP_COUNT];
	assign fired_f = !tl.load && (tl.fired || tl.stim);
	assign v_f     = fired_f ? tl.c : tl.v;
	assign u_f     = fired_f ? snue_pkg::qadd(tl.u, tl.d) : tl.u;

	always_ff @(posedge clk) begin
		if (chv[SUBSTEP_COUNT]) begin
			state_mem[tl.addr[AW-1:0]] <= {u_f, v_f};
			if (tl.load) begin
				param_mem[tl.addr[AW-1:0]] <= {tl.a, tl.b, tl.c, tl.d};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= chv[SUBSTEP_COUNT];
		end
	end

	always_ff @(posedge clk) begin
		res_q <= '{out_index: tl.idx, fired: fired_f, potential: v_f, recovery: u_f};
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

`default_nettype wire

/* hw/rtl/spiking_neuron_update_engine_core.sv */
// Top level of the spiking neuron update engine.
// Depends on snue_pkg, snue_front, snue_back.
//
// Usage: present an item on cmd with start high; it is taken at a rising
// edge where busy is low. A load item writes one neuron's a, b, c, d, u, v
// and echoes u and v; an update item runs SUBSTEP_COUNT Euler substeps on
// the addressed neuron and returns fired, new v and new u.
// Each result appears on result for exactly one cycle with done high; the
// receiver must take it then.
// An accepted item is registered in the front stage, queued, read from the
// table, run through the substep pipelines and registered as the result.
// Throughput: one item per cycle while items address different neurons; an
// item whose neuron is still in the substep pipeline waits in the four-entry
// queue until that neuron is written back; busy rises at three queued entries.
// Reset empties the queue and pipeline; the neuron table is not cleared and
// a neuron must be loaded before it is updated.
`default_nettype none

module spiking_neuron_update_engine_core #(
	parameter int NEURONS       = 1024,
	parameter int SUBSTEP_COUNT = 4
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire snue_pkg::cmd_t  cmd,
	output logic                 busy,
	output logic                 done,
	output snue_pkg::res_t       result
);

	snue_pkg::qhead_t qh;
	logic             pop;

	snue_front #(
		.NEURONS (NEURONS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.qh     (qh),
		.pop    (pop)
	);

	snue_back #(
		.NEURONS       (NEURONS),
		.SUBSTEP_COUNT (SUBSTEP_COUNT)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.qh     (qh),
		.pop    (pop),
		.done   (done),
		.result (result)
	);

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> qh.vld) else $error("pop from empty queue");

	a_busy_queued: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> qh.vld) else $error("busy with empty queue");

endmodule

`default_nettype wire
